// File: hw/rtl/ndpi_pkg.sv
package ndpi_pkg;

    // geometry
    localparam int NDIM      = 4;
    localparam int CW        = 16;
    localparam int VEC_W     = NDIM * CW;
    localparam int SLOTS     = 4;
    localparam int SLOT_BITS = 2;
    localparam int AXIS_W    = 3;

    // stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_TUSER_W = 2;

    // commands
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd3;

    typedef logic [CW-1:0] t_coord;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

// File: hw/rtl/nd_position_iterator_top.sv
// n-dimensional position iterator: a four-axis cursor of 16-bit coordinates
// walks a box set by origin_coords and shape_sizes. iter_axis_order and
// iter_axis_count pick the iteration axes, fastest first; slots past the
// count and repeated axes are dropped, and every other axis is a cursor axis
// whose end coordinate is origin+shape-1. commands on tuser[1:0]: reset puts
// the cursor at the origin, next steps it like an odometer (an overflowing
// axis returns to its origin, except the last, whose overflow raises past_end),
// set loads the iteration axes from tdata, in iteration order or by axis as
// tuser[2] selects. every item gives exactly one result item carrying the new
// cursor, the end position and the flags. an item is captured in the idle
// state; the exec state runs the carry chain and loads the result register,
// and no new item is taken before that. a result that is not taken holds the
// block in its exec state. configuration must be written through a plain write
// port only while idle (the block does not enforce this) and takes effect at
// the next item. reset gives an empty box with past_end set.
module nd_position_iterator_top
    import ndpi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // command items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [63:0] set_coords
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [1:0] cmd, [2] set_in_iter_order
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [63:0] cursor_coords,
                                                  // [127:64] end_coords,
                                                  // [130:128] stepped_axis, rest zero
    output logic [OUT_TUSER_W-1:0] m_axis_tuser   // [0] past_end, [1] at_origin
);

    t_dp_cmd           dp_cmd;
    logic [VEC_W-1:0]  cursor_coords, end_coords;
    logic              past_end, at_origin;
    logic [AXIS_W-1:0] stepped_axis;

    // sequencing and output valid
    ndpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd)
    );

    // config, cursor state, carry chain and result register
    ndpi_datapath u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_index              (i_cfg_index),
        .i_cfg_data               (i_cfg_data),
        .i_cmd                    (dp_cmd),
        .i_item_cmd               (s_axis_tuser[CMD_W-1:0]),
        .i_item_set_coords        (s_axis_tdata[VEC_W-1:0]),
        .i_item_set_in_iter_order (s_axis_tuser[CMD_W]),
        .o_cursor_coords          (cursor_coords),
        .o_end_coords             (end_coords),
        .o_past_end               (past_end),
        .o_at_origin              (at_origin),
        .o_stepped_axis           (stepped_axis)
    );

    // pack result, padding to whole bytes
    assign m_axis_tdata = {(OUT_TDATA_W-2*VEC_W-AXIS_W)'(0), stepped_axis,
                           end_coords, cursor_coords};
    assign m_axis_tuser = {at_origin, past_end};

endmodule

// File: hw/rtl/ndpi_ctrl.sv
module ndpi_ctrl
    import ndpi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_exec_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> r_state == S_EXEC)
        else $error("execute outside exec state");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == S_EXEC)
        else $error("accepted item not taken to exec");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> r_out_valid)
        else $error("executed item produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.execute)
        else $error("pending result overwritten");

endmodule

// File: hw/rtl/ndpi_datapath.sv
module ndpi_datapath
    import ndpi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_dp_cmd                i_cmd,
    input  logic [CMD_W-1:0]       i_item_cmd,
    input  logic [VEC_W-1:0]       i_item_set_coords,
    input  logic                   i_item_set_in_iter_order,
    output logic [VEC_W-1:0]       o_cursor_coords,
    output logic [VEC_W-1:0]       o_end_coords,
    output logic                   o_past_end,
    output logic                   o_at_origin,
    output logic [AXIS_W-1:0]      o_stepped_axis
);

    // configuration
    logic [VEC_W-1:0]         r_origin;
    logic [VEC_W-1:0]         r_shape;
    logic [SLOTS*SLOT_BITS-1:0] r_order;
    logic [2:0]               r_count;

    // state
    t_coord r_cursor [NDIM];
    logic   r_end_flag;

    // captured item
    logic [CMD_W-1:0] r_cmd;
    logic [VEC_W-1:0] r_setv;
    logic             r_in_order;

    // result
    logic [VEC_W-1:0]  r_cur_out, r_end_out;
    logic              r_past_end, r_at_origin;
    logic [AXIS_W-1:0] r_stepped;

    // per-axis limits
    t_coord     org  [NDIM];
    t_coord     shp  [NDIM];
    logic [CW:0] lim [NDIM];
    t_coord     last [NDIM];

    // effective iteration list
    logic [SLOT_BITS-1:0] slot_axis [SLOTS];
    logic                 slot_used [SLOTS];
    logic [SLOT_BITS-1:0] eff_axis  [SLOTS];
    logic                 eff_valid [SLOTS];
    logic [2:0]           eff_n;
    logic                 is_iter   [NDIM];

    // next state
    t_coord            n_cursor [NDIM];
    logic              n_end_flag;
    logic [AXIS_W-1:0] n_stepped;
    logic [VEC_W-1:0]  n_cur_out, n_end_out;
    logic              n_at_origin;

    always_comb begin
        for (int i = 0; i < NDIM; i++) begin
            org[i]  = r_origin[i*CW +: CW];
            shp[i]  = r_shape[i*CW +: CW];
            lim[i]  = {1'b0, org[i]} + {1'b0, shp[i]};
            last[i] = lim[i][CW-1:0] - t_coord'(1);
        end
    end

    // drop slots past the count, axes out of range and repeats
    always_comb begin
        logic [2:0] cnt;
        logic       dup;
        cnt = (r_count > 3'(SLOTS)) ? 3'(SLOTS) : r_count;
        for (int k = 0; k < SLOTS; k++) begin
            slot_axis[k] = r_order[k*SLOT_BITS +: SLOT_BITS];
            dup = 1'b0;
            for (int j = 0; j < k; j++) begin
                if (slot_used[j] && slot_axis[j] == slot_axis[k]) dup = 1'b1;
            end
            slot_used[k] = (3'(k) < cnt) && (int'(slot_axis[k]) < NDIM) && !dup;
        end
    end

    // compact the used slots
    always_comb begin
        logic [2:0] p;
        p = '0;
        for (int k = 0; k < SLOTS; k++) begin
            eff_axis[k]  = '0;
            eff_valid[k] = 1'b0;
        end
        for (int k = 0; k < SLOTS; k++) begin
            if (slot_used[k]) begin
                eff_axis[p[SLOT_BITS-1:0]]  = slot_axis[k];
                eff_valid[p[SLOT_BITS-1:0]] = 1'b1;
                p = p + 3'd1;
            end
        end
        eff_n = p;
        for (int i = 0; i < NDIM; i++) begin
            is_iter[i] = 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                if (slot_used[k] && int'(slot_axis[k]) == i) is_iter[i] = 1'b1;
            end
        end
    end

    always_comb begin
        logic                 carry;
        logic [CW:0]          inc;
        logic [SLOT_BITS-1:0] a;
        t_coord               v;
        carry = 1'b1;
        inc   = '0;
        a     = '0;
        v     = '0;
        for (int i = 0; i < NDIM; i++) n_cursor[i] = r_cursor[i];
        n_end_flag = r_end_flag;
        n_stepped  = '0;
        unique case (r_cmd)
            CMD_RESET: begin
                for (int i = 0; i < NDIM; i++) n_cursor[i] = org[i];
                n_end_flag = (eff_n != 3'd0) ? (shp[eff_axis[0]] == '0) : (shp[0] == '0);
            end
            CMD_NEXT: begin
                if (eff_n == 3'd0) begin
                    for (int i = 0; i < NDIM; i++) n_cursor[i] = last[i];
                    n_end_flag = 1'b1;
                    n_stepped  = AXIS_W'(NDIM);
                end else begin
                    // odometer carry, fastest axis first
                    for (int p = 0; p < SLOTS; p++) begin
                        if (eff_valid[p] && carry) begin
                            a         = eff_axis[p];
                            inc       = {1'b0, r_cursor[a]} + (CW+1)'(1);
                            n_stepped = {1'b0, a};
                            if (inc < lim[a]) begin
                                n_cursor[a] = inc[CW-1:0];
                                carry       = 1'b0;
                            end else if (3'(p + 1) < eff_n) begin
                                n_cursor[a] = org[a];
                            end else begin
                                n_cursor[a] = inc[CW-1:0];
                                n_end_flag  = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_SET: begin
                n_end_flag = 1'b0;
                for (int p = 0; p < SLOTS; p++) begin
                    if (eff_valid[p]) begin
                        a = eff_axis[p];
                        v = r_in_order ? r_setv[p*CW +: CW] : r_setv[a*CW +: CW];
                        n_cursor[a] = v;
                        if ({1'b0, v} >= lim[a]) n_end_flag = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_at_origin = 1'b1;
        for (int i = 0; i < NDIM; i++) begin
            n_cur_out[i*CW +: CW] = n_cursor[i];
            n_end_out[i*CW +: CW] = is_iter[i] ? n_cursor[i] : last[i];
            if (n_cursor[i] != org[i]) n_at_origin = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin   <= '0;
            r_shape    <= '0;
            r_order    <= '0;
            r_count    <= '0;
            r_end_flag <= 1'b1;
            for (int i = 0; i < NDIM; i++) r_cursor[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ORIGIN: r_origin <= i_cfg_data[VEC_W-1:0];
                    CFG_SHAPE:  r_shape  <= i_cfg_data[VEC_W-1:0];
                    CFG_ORDER:  r_order  <= i_cfg_data[SLOTS*SLOT_BITS-1:0];
                    CFG_COUNT:  r_count  <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cmd.execute) begin
                r_end_flag <= n_end_flag;
                for (int i = 0; i < NDIM; i++) r_cursor[i] <= n_cursor[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd      <= i_item_cmd;
            r_setv     <= i_item_set_coords;
            r_in_order <= i_item_set_in_iter_order;
        end
        if (i_cmd.execute) begin
            r_cur_out   <= n_cur_out;
            r_end_out   <= n_end_out;
            r_past_end  <= n_end_flag;
            r_at_origin <= n_at_origin;
            r_stepped   <= n_stepped;
        end
    end

    assign o_cursor_coords = r_cur_out;
    assign o_end_coords    = r_end_out;
    assign o_past_end      = r_past_end;
    assign o_at_origin     = r_at_origin;
    assign o_stepped_axis  = r_stepped;

    a_set_clears_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && r_cmd == CMD_SET && eff_n == 3'd0) |=> !r_end_flag)
        else $error("set with no iteration axes left end flag");

    a_empty_next_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && r_cmd == CMD_NEXT && eff_n == 3'd0)
            |=> (r_end_flag && r_stepped == AXIS_W'(NDIM)))
        else $error("next with no iteration axes did not jump to end");

    a_end_sticky_on_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && r_cmd == CMD_NEXT && r_end_flag) |=> r_end_flag)
        else $error("next cleared end flag");

endmodule
